// ----- hw/rtl/fpr_pkg.sv -----
// shared types, constants and reply byte table for the framed packet receiver
`default_nettype none

package fpr_pkg;

   // frame marker and reply constants
   localparam logic [7:0] SYNC_A    = 8'h42;
   localparam logic [7:0] SYNC_B    = 8'h08;
   localparam logic [7:0] SYNC_C    = 8'h11;
   localparam logic [7:0] ACK_O     = 8'h4F;
   localparam logic [7:0] ACK_K     = 8'h4B;
   localparam logic [7:0] REPLY_LEN = 8'd9;
   localparam logic [7:0] MIN_LEN   = 8'd7;
   localparam logic [7:0] TYPE_POS  = 8'd4;
   localparam logic [3:0] REPLY_LAST = 4'd8;

   // receive phases
   typedef enum logic [2:0] {
      PH_HUNT  = 3'd0,
      PH_SYNC2 = 3'd1,
      PH_SYNC3 = 3'd2,
      PH_LEN   = 3'd3,
      PH_BODY  = 3'd4,
      PH_CHK   = 3'd5,
      PH_CPL   = 3'd6
   } phase_type;

   // result kinds on the output channel
   typedef enum logic [1:0] {
      KIND_BODY   = 2'd0,
      KIND_STATUS = 2'd1,
      KIND_REPLY  = 2'd2
   } kind_type;

   // work handed from front to back
   typedef enum logic [1:0] {
      CMD_BODY         = 2'd0,
      CMD_STATUS       = 2'd1,
      CMD_STATUS_REPLY = 2'd2
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic [7:0] data;
      logic       good;
   } cmd_type;

   // one byte of the acknowledge frame
   function automatic logic [7:0] reply_byte(input logic [3:0] idx,
                                             input logic [7:0] frame_type);
      logic [7:0] sum;
      logic [7:0] val;
      begin
         sum = REPLY_LEN + frame_type + ACK_O + ACK_K;
         unique case (idx)
            4'd0:    val = SYNC_A;
            4'd1:    val = SYNC_B;
            4'd2:    val = SYNC_C;
            4'd3:    val = REPLY_LEN;
            4'd4:    val = frame_type;
            4'd5:    val = ACK_O;
            4'd6:    val = ACK_K;
            4'd7:    val = sum;
            4'd8:    val = ~sum;
            default: val = 8'h00;
         endcase
         reply_byte = val;
      end
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/fpr_queue.sv -----
// small command queue between the parser front and the result back
`default_nettype none

module fpr_queue #(
   parameter int Depth = 4
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  fpr_pkg::cmd_type push_cmd,
   output logic             full,
   input  wire              pop,
   output fpr_pkg::cmd_type head_cmd,
   output logic             empty
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(Depth);

   fpr_pkg::cmd_type entry_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full     = (count_ff == CntFull);
   assign empty    = (count_ff == '0);
   assign head_cmd = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/fpr_front.sv -----
// frame parser: sync hunt, length, checksum and classification of each beat
`default_nettype none

module fpr_front (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_ready,
   input  wire  [7:0]       req_rx_byte,
   input  wire              csr_write_enable,
   input  wire              csr_write_data,
   output logic             push,
   output fpr_pkg::cmd_type push_cmd,
   input  wire              queue_full
);

   fpr_pkg::phase_type phase_ff, phase_in;
   logic [7:0] byte_count_ff, byte_count_in;
   logic [7:0] frame_length_ff, frame_length_in;
   logic [7:0] running_sum_ff, running_sum_in;
   logic [7:0] frame_type_ff, frame_type_in;
   logic       first_check_ok_ff, first_check_ok_in;
   logic       reply_enable_ff;
   logic       accept;
   logic [7:0] count_next;
   logic       body_done;
   logic       frame_ok;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // body end test: count after this beat plus checksum and complement reach length
   assign count_next = byte_count_ff + 8'd1;
   assign body_done  = ({1'b0, count_next} + 9'd2) >= {1'b0, frame_length_ff};
   assign frame_ok   = first_check_ok_ff && (req_rx_byte == ~running_sum_ff);

   // reply enable register
   always_ff @(posedge clock) begin
      if (reset) begin
         reply_enable_ff <= 1'b1;
      end else if (csr_write_enable) begin
         reply_enable_ff <= csr_write_data;
      end
   end

   // next phase, frame state and command to push
   always_comb begin
      phase_in          = phase_ff;
      byte_count_in     = byte_count_ff;
      frame_length_in   = frame_length_ff;
      running_sum_in    = running_sum_ff;
      frame_type_in     = frame_type_ff;
      first_check_ok_in = first_check_ok_ff;
      push              = 1'b0;
      push_cmd          = '{op: fpr_pkg::CMD_STATUS, data: 8'h00, good: 1'b0};
      if (accept) begin
         unique case (phase_ff)
            fpr_pkg::PH_SYNC2: begin
               if (req_rx_byte == fpr_pkg::SYNC_B) begin
                  phase_in = fpr_pkg::PH_SYNC3;
               end else if (req_rx_byte == fpr_pkg::SYNC_A) begin
                  phase_in = fpr_pkg::PH_SYNC2;
               end else begin
                  phase_in = fpr_pkg::PH_HUNT;
               end
            end
            fpr_pkg::PH_SYNC3: begin
               if (req_rx_byte == fpr_pkg::SYNC_C) begin
                  phase_in = fpr_pkg::PH_LEN;
               end else if (req_rx_byte == fpr_pkg::SYNC_A) begin
                  phase_in = fpr_pkg::PH_SYNC2;
               end else begin
                  phase_in = fpr_pkg::PH_HUNT;
               end
            end
            fpr_pkg::PH_LEN: begin
               frame_length_in   = req_rx_byte;
               frame_type_in     = 8'h00;
               first_check_ok_in = 1'b0;
               byte_count_in     = fpr_pkg::TYPE_POS;
               running_sum_in    = req_rx_byte;
               if (req_rx_byte < fpr_pkg::MIN_LEN) begin
                  push     = 1'b1;
                  phase_in = fpr_pkg::PH_HUNT;
               end else begin
                  phase_in = fpr_pkg::PH_BODY;
               end
            end
            fpr_pkg::PH_BODY: begin
               if (byte_count_ff == fpr_pkg::TYPE_POS) begin
                  frame_type_in = req_rx_byte;
               end
               push           = 1'b1;
               push_cmd       = '{op: fpr_pkg::CMD_BODY, data: req_rx_byte, good: 1'b0};
               running_sum_in = running_sum_ff + req_rx_byte;
               byte_count_in  = count_next;
               if (body_done) begin
                  phase_in = fpr_pkg::PH_CHK;
               end
            end
            fpr_pkg::PH_CHK: begin
               first_check_ok_in = (req_rx_byte == running_sum_ff);
               byte_count_in     = count_next;
               phase_in          = fpr_pkg::PH_CPL;
            end
            fpr_pkg::PH_CPL: begin
               byte_count_in = count_next;
               push          = 1'b1;
               push_cmd      = '{op: (frame_ok && reply_enable_ff) ?
                                     fpr_pkg::CMD_STATUS_REPLY : fpr_pkg::CMD_STATUS,
                                 data: frame_type_ff, good: frame_ok};
               phase_in      = fpr_pkg::PH_HUNT;
            end
            default: begin
               phase_in = (req_rx_byte == fpr_pkg::SYNC_A) ?
                          fpr_pkg::PH_SYNC2 : fpr_pkg::PH_HUNT;
            end
         endcase
      end
   end

   // phase and frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= fpr_pkg::PH_HUNT;
         byte_count_ff     <= '0;
         frame_length_ff   <= '0;
         running_sum_ff    <= '0;
         frame_type_ff     <= '0;
         first_check_ok_ff <= 1'b0;
      end else begin
         phase_ff          <= phase_in;
         byte_count_ff     <= byte_count_in;
         frame_length_ff   <= frame_length_in;
         running_sum_ff    <= running_sum_in;
         frame_type_ff     <= frame_type_in;
         first_check_ok_ff <= first_check_ok_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/fpr_back.sv -----
// result generator: turns queued commands into output beats, one per cycle while rsp_ready is high
`default_nettype none

module fpr_back (
   input  wire              clock,
   input  wire              reset,
   input  fpr_pkg::cmd_type head_cmd,
   input  wire              queue_empty,
   output logic             pop,
   output logic             rsp_valid,
   input  wire              rsp_ready,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_data,
   output logic             rsp_frame_good,
   output logic             rsp_last
);

   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] kind_ff, kind_in;
   logic [7:0] data_ff, data_in;
   logic       good_ff, good_in;
   logic       last_ff, last_in;
   logic       busy_ff, busy_in;
   logic [3:0] idx_ff, idx_in;
   logic [7:0] type_ff, type_in;
   logic       load;

   assign load           = !rsp_valid_ff || rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_data       = data_ff;
   assign rsp_frame_good = good_ff;
   assign rsp_last       = last_ff;

   // pick the next beat: reply bytes in progress first, then the queue head
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      data_in      = data_ff;
      good_in      = good_ff;
      last_in      = last_ff;
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      type_in      = type_ff;
      pop          = 1'b0;
      if (load) begin
         if (busy_ff) begin
            rsp_valid_in = 1'b1;
            kind_in      = fpr_pkg::KIND_REPLY;
            data_in      = fpr_pkg::reply_byte(idx_ff, type_ff);
            good_in      = 1'b0;
            last_in      = (idx_ff == fpr_pkg::REPLY_LAST);
            busy_in      = (idx_ff != fpr_pkg::REPLY_LAST);
            idx_in       = idx_ff + 4'd1;
         end else if (!queue_empty) begin
            pop          = 1'b1;
            rsp_valid_in = 1'b1;
            data_in      = head_cmd.data;
            good_in      = head_cmd.good;
            unique case (head_cmd.op)
               fpr_pkg::CMD_BODY: begin
                  kind_in = fpr_pkg::KIND_BODY;
                  last_in = 1'b1;
               end
               fpr_pkg::CMD_STATUS_REPLY: begin
                  kind_in = fpr_pkg::KIND_STATUS;
                  last_in = 1'b0;
                  busy_in = 1'b1;
                  idx_in  = '0;
                  type_in = head_cmd.data;
               end
               default: begin
                  kind_in = fpr_pkg::KIND_STATUS;
                  last_in = 1'b1;
               end
            endcase
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
      end
   end

   // output beat and reply type registers
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      data_ff <= data_in;
      good_ff <= good_in;
      last_ff <= last_in;
      type_ff <= type_in;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/framed_packet_receiver_with_ack_top.sv -----
// framed packet receiver with acknowledge reply, top level
// the first result beat of a byte becomes valid after the queue write and then the output
// register load, when the back is idle
// throughput: one byte per cycle in; one result beat per cycle out, set by the output register,
// while rsp_ready is high; a good frame's closing byte yields 10 beats when replies are enabled,
// and input stalls once the command queue (QueueDepth entries) is full
// reset: synchronous; hunts for sync, reply enabled, queue and output empty
`default_nettype none

module framed_packet_receiver_with_ack_top #(
   parameter int QueueDepth = 4
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   input  wire  [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data,
   output logic       rsp_frame_good,
   output logic       rsp_last,
   input  wire        csr_write_enable,
   input  wire        csr_write_data
);

   fpr_pkg::cmd_type push_cmd;
   fpr_pkg::cmd_type head_cmd;
   logic push, pop, queue_full, queue_empty;

   // parser front
   fpr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .push             (push),
      .push_cmd         (push_cmd),
      .queue_full       (queue_full)
   );

   // command queue
   fpr_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (queue_empty)
   );

   // result back
   fpr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_cmd       (head_cmd),
      .queue_empty    (queue_empty),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_data       (rsp_data),
      .rsp_frame_good (rsp_frame_good),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire
